// ===== rtl/core/lpmr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types and constants of the length-prefixed message ring.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmr_pkg;

    // Header is a fixed 4-byte little-endian length word
    localparam int unsigned HEADER_BYTES = 4;
    localparam logic [7:0]  RESERVE_RESET = 8'd4;

    typedef enum logic [1:0] {
        REQ_APPEND_START = 2'd0,
        REQ_APPEND_BYTE  = 2'd1,
        REQ_FETCH_START  = 2'd2,
        REQ_FETCH_BYTE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_BAD_LENGTH = 3'd1,
        STS_FULL       = 3'd2,
        STS_EMPTY      = 3'd3,
        STS_FLUSHED    = 3'd4,
        STS_TOO_SMALL  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_WR_HDR  = 3'd1,
        S_RD_HDR  = 3'd2,
        S_CHECK   = 3'd3,
        S_RD_BYTE = 3'd4
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/length_prefixed_message_ring_unit.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_unit
// Byte ring holding length-prefixed messages in one synchronous RAM.
//
//   channel   handshake                 payload
//   -------   -----------------------   -------------------------------------
//   request   start & !busy             i_req_type, i_msg_length,
//                                       i_data_byte, i_out_limit
//   result    o_valid (one cycle)       o_status, o_start_offset,
//                                       o_length_out, o_byte_out, o_last
//   config    i_cfg_we                  i_cfg_wdata (reserve_bytes)
//
// Timing: append_byte and every request refused without a RAM access
// answer with a result in the next cycle (busy never raised). fetch_byte
// reads the RAM and answers from S_RD_BYTE. append_start does one RAM write per
// header byte in S_WR_HDR, fetch_start four header reads through the single read
// port, then the length check in S_CHECK, whatever status it ends with.
// The result of one request overlaps acceptance of the next one.
// Reset clears all pointers and counters; the RAM content is not cleared.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_message_ring_unit #(
    parameter int unsigned RING_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_msg_length,
    input  logic [7:0]  i_data_byte,
    input  logic [11:0] i_out_limit,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [11:0] o_start_offset,
    output logic [11:0] o_length_out,
    output logic [7:0]  o_byte_out,
    output logic        o_last
);

    localparam int unsigned IW = $clog2(RING_BYTES);
    localparam int unsigned SW = ((IW > 12) ? IW : 12) + 2;
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_BYTES - 1);
    localparam logic [1:0] HDR_LAST = 2'(lpmr_pkg::HEADER_BYTES - 1);

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    // control / pointer state
    lpmr_pkg::t_state r_state, n_state;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic [IW-1:0] r_wr_idx, n_wr_idx;
    logic [IW-1:0] r_pend_idx, n_pend_idx;
    logic [11:0]   r_app_rem, n_app_rem;
    logic [IW-1:0] r_cursor, n_cursor;
    logic [IW-1:0] r_fetch_rem, n_fetch_rem;
    logic [7:0]    r_reserve, n_reserve;
    logic [IW-1:0] r_ptr, n_ptr;
    logic [1:0]    r_cnt, n_cnt;
    logic          r_valid, n_valid;

    // working payload
    logic [11:0]   r_len, n_len;
    logic [11:0]   r_limit, n_limit;
    logic [31:0]   r_hdr, n_hdr;

    // result beat
    lpmr_pkg::t_status r_status, n_status;
    logic [11:0]   r_start_off, n_start_off;
    logic [11:0]   r_len_out, n_len_out;
    logic [7:0]    r_byte, n_byte;
    logic          r_last, n_last;

    // ring RAM
    logic [7:0]    mem [RING_BYTES];
    logic [7:0]    r_rd_data;
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    logic [IW-1:0] used;
    logic          no_room;
    logic          hdr_bad;
    logic [31:0]   hdr_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    always_comb begin
        if (r_rd_idx > r_wr_idx) begin
            used = IW'((IW+1)'(RING_BYTES) - {1'b0, r_rd_idx} + {1'b0, r_wr_idx});
        end else begin
            used = r_wr_idx - r_rd_idx;
        end
    end

    assign no_room = (SW'(used) + SW'(r_reserve) + SW'(lpmr_pkg::HEADER_BYTES)
                      + SW'(i_msg_length)) > SW'(RING_BYTES);
    // stated length larger than what follows the header
    assign hdr_bad = r_hdr > (32'(used) - 32'(lpmr_pkg::HEADER_BYTES));
    assign hdr_word = {20'd0, r_len};

    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_pend_idx  = r_pend_idx;
        n_app_rem   = r_app_rem;
        n_cursor    = r_cursor;
        n_fetch_rem = r_fetch_rem;
        n_reserve   = i_cfg_we ? i_cfg_wdata : r_reserve;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_limit     = r_limit;
        n_hdr       = r_hdr;
        n_valid     = 1'b0;
        n_status    = lpmr_pkg::STS_OK;
        n_start_off = '0;
        n_len_out   = '0;
        n_byte      = '0;
        n_last      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_ptr;
        mem_wdata   = hdr_word[8*r_cnt +: 8];
        mem_re      = 1'b0;
        mem_raddr   = r_ptr;

        unique case (r_state)
            lpmr_pkg::S_IDLE: begin
                if (start) begin
                    unique case (lpmr_pkg::t_req'(i_req_type))
                        lpmr_pkg::REQ_APPEND_START: begin
                            n_app_rem = '0;   // drops any open append
                            if (i_msg_length == '0) begin
                                n_valid  = 1'b1;
                                n_status = lpmr_pkg::STS_BAD_LENGTH;
                            end else if (no_room) begin
                                n_valid  = 1'b1;
                                n_status = lpmr_pkg::STS_FULL;
                            end else begin
                                n_state = lpmr_pkg::S_WR_HDR;
                                n_ptr   = r_wr_idx;
                                n_cnt   = '0;
                                n_len   = i_msg_length;
                            end
                        end
                        lpmr_pkg::REQ_APPEND_BYTE: begin
                            n_valid = 1'b1;
                            if (r_app_rem == '0) begin
                                n_status = lpmr_pkg::STS_BAD_LENGTH;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = r_pend_idx;
                                mem_wdata  = i_data_byte;
                                n_pend_idx = ring_next(r_pend_idx);
                                n_app_rem  = r_app_rem - 1'b1;
                                if (r_app_rem == 12'd1) begin
                                    n_wr_idx = ring_next(r_pend_idx);  // commit
                                    n_last   = 1'b1;
                                end
                            end
                        end
                        lpmr_pkg::REQ_FETCH_START: begin
                            n_fetch_rem = '0;
                            if (used == '0) begin
                                n_valid  = 1'b1;
                                n_status = lpmr_pkg::STS_EMPTY;
                            end else if (32'(used) < 32'(lpmr_pkg::HEADER_BYTES)) begin
                                n_valid  = 1'b1;
                                n_status = lpmr_pkg::STS_FLUSHED;
                                n_rd_idx = r_wr_idx;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_rd_idx;
                                n_ptr     = ring_next(r_rd_idx);
                                n_cnt     = '0;
                                n_limit   = i_out_limit;
                                n_state   = lpmr_pkg::S_RD_HDR;
                            end
                        end
                        lpmr_pkg::REQ_FETCH_BYTE: begin
                            if (r_fetch_rem == '0) begin
                                n_valid  = 1'b1;
                                n_status = lpmr_pkg::STS_EMPTY;
                            end else begin
                                mem_re      = 1'b1;
                                mem_raddr   = r_cursor;
                                n_cursor    = ring_next(r_cursor);
                                n_fetch_rem = r_fetch_rem - 1'b1;
                                if (r_fetch_rem == IW'(1)) begin
                                    n_rd_idx = ring_next(r_cursor);
                                end
                                n_state = lpmr_pkg::S_RD_BYTE;
                            end
                        end
                        default: begin
                            n_state = lpmr_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            lpmr_pkg::S_WR_HDR: begin
                mem_we = 1'b1;
                n_ptr  = ring_next(r_ptr);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == HDR_LAST) begin
                    n_pend_idx  = ring_next(r_ptr);
                    n_app_rem   = r_len;
                    n_valid     = 1'b1;
                    n_start_off = 12'(r_wr_idx);
                    n_state     = lpmr_pkg::S_IDLE;
                end
            end
            lpmr_pkg::S_RD_HDR: begin
                n_hdr[8*r_cnt +: 8] = r_rd_data;
                if (r_cnt == HDR_LAST) begin
                    n_state = lpmr_pkg::S_CHECK;
                end else begin
                    mem_re = 1'b1;
                    n_ptr  = ring_next(r_ptr);
                    n_cnt  = r_cnt + 1'b1;
                end
            end
            lpmr_pkg::S_CHECK: begin
                n_valid = 1'b1;
                n_state = lpmr_pkg::S_IDLE;
                if (hdr_bad) begin
                    n_status = lpmr_pkg::STS_FLUSHED;
                    n_rd_idx = r_wr_idx;
                end else if (r_hdr > 32'(r_limit)) begin
                    n_status  = lpmr_pkg::STS_TOO_SMALL;
                    n_len_out = r_hdr[11:0];
                end else begin
                    n_len_out   = r_hdr[11:0];
                    n_cursor    = r_ptr;
                    n_fetch_rem = IW'(r_hdr);
                    if (r_hdr == '0) begin
                        n_rd_idx = r_ptr;   // empty message: consume header only
                    end
                end
            end
            lpmr_pkg::S_RD_BYTE: begin
                n_valid = 1'b1;
                n_byte  = r_rd_data;
                n_last  = (r_fetch_rem == '0);
                n_state = lpmr_pkg::S_IDLE;
            end
            default: begin
                n_state = lpmr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpmr_pkg::S_IDLE;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_pend_idx  <= '0;
            r_app_rem   <= '0;
            r_cursor    <= '0;
            r_fetch_rem <= '0;
            r_reserve   <= lpmr_pkg::RESERVE_RESET;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_pend_idx  <= n_pend_idx;
            r_app_rem   <= n_app_rem;
            r_cursor    <= n_cursor;
            r_fetch_rem <= n_fetch_rem;
            r_reserve   <= n_reserve;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_limit     <= n_limit;
        r_hdr       <= n_hdr;
        r_status    <= n_status;
        r_start_off <= n_start_off;
        r_len_out   <= n_len_out;
        r_byte      <= n_byte;
        r_last      <= n_last;
    end

    assign busy           = (r_state != lpmr_pkg::S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_start_offset = r_start_off;
    assign o_length_out   = r_len_out;
    assign o_byte_out     = r_byte;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// ===== rtl/core/lpmr_chk.sv =====
// ----------------------------------------------------------------------------
// lpmr_chk
// Port-level checks of the message ring, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [2:0] o_status,
    input logic [7:0] o_byte_out,
    input logic       o_last
);

    // an accepted beat either answers at once or holds the request side off
    a_accept_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted request neither answered nor busy");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != lpmr_pkg::STS_OK)) |-> (!o_last && (o_byte_out == 8'd0)))
        else $error("error result carries payload or last");

    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_status == lpmr_pkg::STS_OK))
        else $error("last flagged on a failed request");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!busy && !o_valid))
        else $error("activity right after reset");

endmodule

bind length_prefixed_message_ring_unit lpmr_chk u_lpmr_chk (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed message ring. A scoreboard
// class tracks the ring state and predicts each result beat, which is then
// compared field by field with what the unit returns. Stimulus is a directed
// opening, then randomized message traffic under several reserve settings,
// each started with a probe of the exact free-space edge.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RING = 4096;

    typedef struct packed {
        lpmr_pkg::t_status status;
        logic [11:0]       start_offset;
        logic [11:0]       length_out;
        logic [7:0]        byte_out;
        logic              is_last;
    } t_ring_reply;

    class t_ring_scoreboard;
        logic [7:0]  mem [RING];
        logic [11:0] rd_idx, wr_idx, pend_idx, cursor;
        int unsigned append_left, fetch_left, reserve;
        t_ring_reply pending_q [$];
        int unsigned n_checked, n_errors;
        int unsigned status_seen [6];

        function new();
            foreach (mem[i]) mem[i] = 8'h00;
            rd_idx = '0;
            wr_idx = '0;
            pend_idx = '0;
            cursor = '0;
            append_left = 0;
            fetch_left = 0;
            reserve = lpmr_pkg::RESERVE_RESET;
            n_checked = 0;
            n_errors = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // 12-bit index difference wraps exactly like the ring
        function int unsigned used_bytes();
            logic [11:0] span;
            span = wr_idx - rd_idx;
            return span;
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction

        function t_ring_reply note_request(lpmr_pkg::t_req req, logic [11:0] len,
                                           logic [7:0] dbyte, logic [11:0] limit);
            t_ring_reply r;
            logic [11:0] p;
            logic [31:0] hdr;
            int unsigned used;
            r = '0;
            r.status = lpmr_pkg::STS_OK;
            used = used_bytes();
            case (req)
                lpmr_pkg::REQ_APPEND_START: begin
                    append_left = 0;
                    if (len == 0) begin
                        r.status = lpmr_pkg::STS_BAD_LENGTH;
                    end else if (used + reserve + lpmr_pkg::HEADER_BYTES + len > RING) begin
                        r.status = lpmr_pkg::STS_FULL;
                    end else begin
                        r.start_offset = wr_idx;
                        p = wr_idx;
                        for (int i = 0; i < lpmr_pkg::HEADER_BYTES; i++) begin
                            mem[p] = 8'(len >> (8 * i));
                            p++;
                        end
                        pend_idx = p;
                        append_left = len;
                    end
                end
                lpmr_pkg::REQ_APPEND_BYTE: begin
                    if (append_left == 0) begin
                        r.status = lpmr_pkg::STS_BAD_LENGTH;
                    end else begin
                        mem[pend_idx] = dbyte;
                        pend_idx++;
                        append_left--;
                        if (append_left == 0) begin
                            wr_idx = pend_idx;
                            r.is_last = 1'b1;
                        end
                    end
                end
                lpmr_pkg::REQ_FETCH_START: begin
                    fetch_left = 0;
                    if (used == 0) begin
                        r.status = lpmr_pkg::STS_EMPTY;
                    end else if (used < lpmr_pkg::HEADER_BYTES) begin
                        rd_idx = wr_idx;
                        r.status = lpmr_pkg::STS_FLUSHED;
                    end else begin
                        hdr = '0;
                        p = rd_idx;
                        for (int i = 0; i < lpmr_pkg::HEADER_BYTES; i++) begin
                            hdr |= 32'(mem[p]) << (8 * i);
                            p++;
                        end
                        if (hdr > used - lpmr_pkg::HEADER_BYTES) begin
                            rd_idx = wr_idx;
                            r.status = lpmr_pkg::STS_FLUSHED;
                        end else if (hdr > limit) begin
                            r.status = lpmr_pkg::STS_TOO_SMALL;
                            r.length_out = hdr[11:0];
                        end else begin
                            r.length_out = hdr[11:0];
                            cursor = p;
                            fetch_left = hdr;
                            // empty message: commit past the header right away
                            if (hdr == 0) rd_idx = p;
                        end
                    end
                end
                default: begin
                    if (fetch_left == 0) begin
                        r.status = lpmr_pkg::STS_EMPTY;
                    end else begin
                        r.byte_out = mem[cursor];
                        cursor++;
                        fetch_left--;
                        if (fetch_left == 0) begin
                            rd_idx = cursor;
                            r.is_last = 1'b1;
                        end
                    end
                end
            endcase
            pending_q.push_back(r);
            return r;
        endfunction

        function void check_reply(t_ring_reply got);
            t_ring_reply want;
            if (pending_q.size() == 0) begin
                $error("result beat with no request outstanding, status %0d", got.status);
                n_errors++;
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            status_seen[want.status]++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                n_errors++;
            end
            if (got.start_offset !== want.start_offset) begin
                $error("start_offset: expected %0d, actual %0d",
                       want.start_offset, got.start_offset);
                n_errors++;
            end
            if (got.length_out !== want.length_out) begin
                $error("length_out: expected %0d, actual %0d",
                       want.length_out, got.length_out);
                n_errors++;
            end
            if (got.byte_out !== want.byte_out) begin
                $error("byte_out: expected 0x%02h, actual 0x%02h",
                       want.byte_out, got.byte_out);
                n_errors++;
            end
            if (got.is_last !== want.is_last) begin
                $error("last: expected %0b, actual %0b", want.is_last, got.is_last);
                n_errors++;
            end
        endfunction

        function void drop_all();
            pending_q.delete();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [11:0] i_msg_length;
    logic [7:0]  i_data_byte;
    logic [11:0] i_out_limit;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [11:0] o_start_offset;
    logic [11:0] o_length_out;
    logic [7:0]  o_byte_out;
    logic        o_last;

    t_ring_scoreboard sb = new();
    t_ring_reply    reply;
    t_ring_reply    seen;
    int unsigned    item_count = 0;
    int unsigned    calm_left = 0;
    logic [7:0]     reserve_plan [4];

    length_prefixed_message_ring_unit #(
        .RING_BYTES(RING)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_msg_length   (i_msg_length),
        .i_data_byte    (i_data_byte),
        .i_out_limit    (i_out_limit),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_start_offset (o_start_offset),
        .o_length_out   (o_length_out),
        .o_byte_out     (o_byte_out),
        .o_last         (o_last)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            seen.status       = lpmr_pkg::t_status'(o_status);
            seen.start_offset = o_start_offset;
            seen.length_out   = o_length_out;
            seen.byte_out     = o_byte_out;
            seen.is_last      = o_last;
            sb.check_reply(seen);
        end
    end

    function automatic logic [11:0] rand12();
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly back-to-back beats, some short gaps, a few long ones,
    // and now and then a calm stretch with no gaps at all
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r < 3) begin
            calm_left = $urandom_range(20, 120);
            return 0;
        end
        if (r < 110) return 0;
        if (r < 180) return $urandom_range(1, 3);
        if (r < 195) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input lpmr_pkg::t_req req, input logic [11:0] len,
                             input logic [7:0] dbyte, input logic [11:0] limit);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            start = 1'b0;
            repeat (gap) begin
                i_req_type   = 2'($urandom_range(0, 3));
                i_msg_length = rand12();
                i_data_byte  = rand8();
                i_out_limit  = rand12();
                @(negedge i_clk);
            end
        end
        start        = 1'b1;
        i_req_type   = req;
        i_msg_length = len;
        i_data_byte  = dbyte;
        i_out_limit  = limit;
        do @(posedge i_clk); while (busy);
        reply = sb.note_request(req, len, dbyte, limit);
        item_count++;
    endtask

    task automatic wait_drained();
        int unsigned waited;
        @(negedge i_clk);
        start = 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.pending() != 0) begin
            $error("%0d expected result beats never arrived", sb.pending());
            sb.n_errors += sb.pending();
            sb.drop_all();
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reserve(input logic [7:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        sb.reserve = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = rand8();
    endtask

    task automatic append_message(input logic [11:0] len, input int unsigned n_bytes);
        send_item(lpmr_pkg::REQ_APPEND_START, len, rand8(), rand12());
        if (reply.status == lpmr_pkg::STS_OK)
            repeat (n_bytes)
                send_item(lpmr_pkg::REQ_APPEND_BYTE, rand12(), rand8(), rand12());
    endtask

    task automatic fetch_message(input logic [11:0] limit, input int unsigned max_bytes);
        int unsigned n;
        send_item(lpmr_pkg::REQ_FETCH_START, rand12(), rand8(), limit);
        n = 0;
        if (reply.status == lpmr_pkg::STS_OK)
            n = (reply.length_out < max_bytes) ? reply.length_out : max_bytes;
        repeat (n) send_item(lpmr_pkg::REQ_FETCH_BYTE, rand12(), rand8(), rand12());
    endtask

    // one length past the free space, then the exact fit (left open)
    task automatic probe_space_edge();
        int room;
        room = int'(RING) - int'(sb.used_bytes()) - int'(sb.reserve)
               - int'(lpmr_pkg::HEADER_BYTES);
        if (room >= 1 && room < 4095)
            send_item(lpmr_pkg::REQ_APPEND_START, 12'(room + 1), rand8(), rand12());
        if (room >= 1 && room <= 4095)
            send_item(lpmr_pkg::REQ_APPEND_START, 12'(room), rand8(), rand12());
        else
            send_item(lpmr_pkg::REQ_APPEND_START, 12'd1, rand8(), rand12());
    endtask

    task automatic random_traffic(input int unsigned n_items);
        int unsigned stop_at, r, s, len, n;
        logic [11:0] limit;
        stop_at = item_count + n_items;
        while (item_count < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                s = $urandom_range(0, 99);
                if (s < 4)       len = 0;
                else if (s < 88) len = $urandom_range(1, 12);
                else if (s < 96) len = $urandom_range(13, 40);
                else if (s < 98) len = $urandom_range(3700, 4095);
                else             len = $urandom_range(41, 4095);
                if (len > 40)
                    n = $urandom_range(0, 6);
                else if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(0, len);
                else
                    n = len;
                append_message(12'(len), n);
            end else if (r < 80) begin
                s = $urandom_range(0, 99);
                if (s < 75)      limit = 12'($urandom_range(40, 4095));
                else if (s < 92) limit = 12'($urandom_range(0, 12));
                else if (s < 96) limit = 12'd0;
                else             limit = 12'hFFF;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : RING;
                fetch_message(limit, n);
            end else if (r < 90) begin
                send_item((r < 85) ? lpmr_pkg::REQ_FETCH_BYTE : lpmr_pkg::REQ_APPEND_BYTE,
                          rand12(), rand8(), rand12());
            end else begin
                send_item(lpmr_pkg::t_req'($urandom_range(0, 3)),
                          rand12(), rand8(), rand12());
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req_type   = lpmr_pkg::REQ_APPEND_START;
        i_msg_length = '0;
        i_data_byte  = '0;
        i_out_limit  = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed opening, reset reserve
        send_item(lpmr_pkg::REQ_FETCH_START, rand12(), rand8(), 12'hFFF);
        send_item(lpmr_pkg::REQ_FETCH_BYTE, rand12(), rand8(), rand12());
        send_item(lpmr_pkg::REQ_APPEND_BYTE, rand12(), 8'hFF, rand12());
        send_item(lpmr_pkg::REQ_APPEND_START, 12'd0, rand8(), rand12());
        send_item(lpmr_pkg::REQ_APPEND_START, 12'hFFF, rand8(), rand12());
        send_item(lpmr_pkg::REQ_APPEND_START, 12'd3, rand8(), rand12());
        send_item(lpmr_pkg::REQ_APPEND_BYTE, rand12(), 8'h00, rand12());
        send_item(lpmr_pkg::REQ_APPEND_BYTE, rand12(), 8'hFF, rand12());
        send_item(lpmr_pkg::REQ_APPEND_BYTE, rand12(), 8'hA5, rand12());
        send_item(lpmr_pkg::REQ_APPEND_START, 12'd5, rand8(), rand12());
        send_item(lpmr_pkg::REQ_APPEND_BYTE, rand12(), 8'h11, rand12());
        // append still open: fetches see only the committed message
        send_item(lpmr_pkg::REQ_FETCH_START, rand12(), rand8(), 12'd2);
        send_item(lpmr_pkg::REQ_FETCH_START, rand12(), rand8(), 12'hFFF);
        send_item(lpmr_pkg::REQ_FETCH_BYTE, rand12(), rand8(), rand12());
        send_item(lpmr_pkg::REQ_FETCH_START, rand12(), rand8(), 12'd3);
        repeat (3) send_item(lpmr_pkg::REQ_FETCH_BYTE, rand12(), rand8(), rand12());
        send_item(lpmr_pkg::REQ_APPEND_START, 12'd1, rand8(), rand12());
        send_item(lpmr_pkg::REQ_APPEND_BYTE, rand12(), 8'h5A, rand12());
        probe_space_edge();
        send_item(lpmr_pkg::REQ_FETCH_START, rand12(), rand8(), 12'd0);
        send_item(lpmr_pkg::REQ_FETCH_START, rand12(), rand8(), 12'd1);
        send_item(lpmr_pkg::REQ_FETCH_BYTE, rand12(), rand8(), rand12());

        reserve_plan[0] = 8'd255;
        reserve_plan[1] = 8'd0;
        reserve_plan[2] = 8'($urandom_range(1, 254));
        reserve_plan[3] = lpmr_pkg::RESERVE_RESET;
        foreach (reserve_plan[i]) begin
            write_reserve(reserve_plan[i]);
            probe_space_edge();
            random_traffic(350);
        end

        wait_drained();
        $display("Checked %0d result beats from %0d requests at reserve 255, 0, %0d, %0d",
                 sb.n_checked, item_count, reserve_plan[2], reserve_plan[3]);
        $display("statuses: ok %0d, bad_length %0d, full %0d, empty %0d, %s %0d, %s %0d",
                 sb.status_seen[lpmr_pkg::STS_OK], sb.status_seen[lpmr_pkg::STS_BAD_LENGTH],
                 sb.status_seen[lpmr_pkg::STS_FULL], sb.status_seen[lpmr_pkg::STS_EMPTY],
                 "flushed", sb.status_seen[lpmr_pkg::STS_FLUSHED],
                 "too_small", sb.status_seen[lpmr_pkg::STS_TOO_SMALL]);
        if (sb.n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #1_000_000;
        $error("run did not finish in time");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lpmr_pkg.sv
rtl/core/length_prefixed_message_ring_unit.sv
rtl/core/lpmr_chk.sv
bench/tb_top.sv
